// ----- rtl/core/rdv_pkg.sv -----
// ============================================================================
// rdv_pkg
// Shared widths, register indexes, pipeline lane types and divider steps for
// the voxel relaxation core.
// ============================================================================
package rdv_pkg;

    localparam int LEVEL_W    = 24;
    localparam int WEIGHT_W   = 17;
    localparam int NSUM_W     = 27;
    localparam int SINK_W     = 32;
    localparam int SDIV_W     = 25;
    localparam int DEN_W      = 34;
    localparam int RHS_W      = 52;
    localparam int CAND_W     = 24;
    localparam int IN_DATA_W  = 216;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 8;

    // Quotient bits resolved by each divider, one per stage
    localparam int SINK_BITS  = SINK_W;
    localparam int MDIV_BITS  = CAND_W;

    // Input, decode, sink divider, sum, main divider, relax, output
    localparam int PIPE_DEPTH = 2 + (SINK_BITS + 1) + 1 + (MDIV_BITS + 1) + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VX_RATE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VESSEL    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_R_HALF    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_K_HALF    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_THIN      = 8'd7;

    typedef struct packed {
        logic [SDIV_W-1:0] rem;
        logic [SINK_W-1:0] nq;
        logic [SDIV_W-1:0] div;
        logic              sat;
    } sink_lane_t;

    typedef struct packed {
        logic [DEN_W-1:0]   rem;
        logic [CAND_W-1:0]  nq;
        logic [DEN_W-1:0]   den;
        logic               den_zero;
        logic [LEVEL_W-1:0] old;
        logic               offl;
    } mdiv_lane_t;

    // One restoring step of the sink divider
    function automatic sink_lane_t sink_step(sink_lane_t s);
        sink_lane_t        n;
        logic [SDIV_W:0]   t;
        logic [SDIV_W:0]   diff;
        n    = s;
        t    = {s.rem, s.nq[SINK_W-1]};
        diff = t - {1'b0, s.div};
        n.nq = {s.nq[SINK_W-2:0], 1'b0};
        if (t >= {1'b0, s.div})
        begin
            n.rem   = diff[SDIV_W-1:0];
            n.nq[0] = 1'b1;
        end
        else
        begin
            n.rem = t[SDIV_W-1:0];
        end
        return n;
    endfunction

    // One restoring step of the main divider
    function automatic mdiv_lane_t mdiv_step(mdiv_lane_t s);
        mdiv_lane_t     n;
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        n    = s;
        t    = {s.rem, s.nq[CAND_W-1]};
        diff = t - {1'b0, s.den};
        n.nq = {s.nq[CAND_W-2:0], 1'b0};
        if (t >= {1'b0, s.den})
        begin
            n.rem   = diff[DEN_W-1:0];
            n.nq[0] = 1'b1;
        end
        else
        begin
            n.rem = t[DEN_W-1:0];
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/rdv_sink_div.sv -----
// ============================================================================
// rdv_sink_div
// Two pipelined restoring dividers for the Michaelis-Menten sinks,
// (uptake << 16) / divisor, saturated to all ones.
// ============================================================================
module rdv_sink_div
    import rdv_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [LEVEL_W-1:0]   r_uptake,
    input  logic [SDIV_W-1:0]    r_divisor,
    input  logic [LEVEL_W-1:0]   k_uptake,
    input  logic [SDIV_W-1:0]    k_divisor,
    output logic [SINK_W-1:0]    r_sink,
    output logic [SINK_W-1:0]    k_sink
);

    sink_lane_t r_reg [0:SINK_BITS];
    sink_lane_t k_reg [0:SINK_BITS];
    sink_lane_t r_init;
    sink_lane_t k_init;

    // Saturate when the quotient would not fit; a zero divisor lands here too
    always_comb
    begin
        r_init.div = r_divisor;
        r_init.rem = {{(SDIV_W-8){1'b0}}, r_uptake[LEVEL_W-1:16]};
        r_init.nq  = {r_uptake[15:0], 16'h0000};
        r_init.sat = (r_divisor[SDIV_W-1:8] == '0) &&
                     (r_uptake >= {r_divisor[7:0], 16'h0000});
        k_init.div = k_divisor;
        k_init.rem = {{(SDIV_W-8){1'b0}}, k_uptake[LEVEL_W-1:16]};
        k_init.nq  = {k_uptake[15:0], 16'h0000};
        k_init.sat = (k_divisor[SDIV_W-1:8] == '0) &&
                     (k_uptake >= {k_divisor[7:0], 16'h0000});
    end

    // Advance one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= r_init;
            k_reg[0] <= k_init;
            for (int i = 0; i < SINK_BITS; i++)
            begin
                r_reg[i+1] <= sink_step(r_reg[i]);
                k_reg[i+1] <= sink_step(k_reg[i]);
            end
        end
    end

    assign r_sink = r_reg[SINK_BITS].sat ? '1 : r_reg[SINK_BITS].nq;
    assign k_sink = k_reg[SINK_BITS].sat ? '1 : k_reg[SINK_BITS].nq;

endmodule

// ----- rtl/core/reaction_diffusion_voxel_relax_core.sv -----
// Throughput: one voxel per cycle while the output is not stalled; the 32-stage sink dividers and 24-stage
// main divider each resolve one quotient bit per stage.
// A stalled output holds the whole pipeline; nothing is dropped.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the
// register defaults.
// ============================================================================
// reaction_diffusion_voxel_relax_core
// Weighted Jacobi relaxation of one voxel of steady reaction-diffusion with
// decay, vessel exchange and two saturating uptake sinks.
// ============================================================================
module reaction_diffusion_voxel_relax_core
    import rdv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // old_level, nbr_x_minus, nbr_x_plus, nbr_y_minus, nbr_y_plus,
    // nbr_z_minus, nbr_z_plus, r_uptake, k_uptake (24 bits each)
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // perfused, on_base_layer
    input  logic [IN_USER_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_level, level_change (24 bits each)
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_data
);

    localparam int SD = SINK_BITS + 1;

    logic [LEVEL_W-1:0]  diff_rate_reg, decay_reg, vx_rate_reg, vessel_reg;
    logic [LEVEL_W-1:0]  r_half_reg, k_half_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                thin_reg;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  en;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_rate_reg <= 24'd65536;
            decay_reg     <= 24'd0;
            vx_rate_reg   <= 24'd65536;
            vessel_reg    <= 24'd65536;
            weight_reg    <= 17'd65536;
            r_half_reg    <= 24'd6554;
            k_half_reg    <= 24'd6554;
            thin_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DIFFUSION: diff_rate_reg <= cfg_data;
                CFG_DECAY:     decay_reg     <= cfg_data;
                CFG_VX_RATE:   vx_rate_reg   <= cfg_data;
                CFG_VESSEL:    vessel_reg    <= cfg_data;
                CFG_WEIGHT:    weight_reg    <= cfg_data[WEIGHT_W-1:0];
                CFG_R_HALF:    r_half_reg    <= cfg_data;
                CFG_K_HALF:    k_half_reg    <= cfg_data;
                CFG_THIN:      thin_reg      <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Global advance: move everything when the output slot is free or taken
    assign en            = !vld_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    // Stage A: capture the beat
    logic [IN_DATA_W-1:0] a_data_reg;
    logic [IN_USER_W-1:0] a_user_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_data_reg <= s_axis_tdata;
            a_user_reg <= s_axis_tuser;
        end
    end

    // Stage B: neighbour sum, sink divisors, off-layer flag
    logic [LEVEL_W-1:0] a_old;
    logic [NSUM_W-1:0]  a_nsum;
    logic [LEVEL_W-1:0] b_old_reg, b_r_up_reg, b_k_up_reg;
    logic [NSUM_W-1:0]  b_nsum_reg;
    logic [SDIV_W-1:0]  b_r_div_reg, b_k_div_reg;
    logic               b_perf_reg, b_offl_reg, b_thin_reg;

    always_comb
    begin
        a_old  = a_data_reg[23:0];
        a_nsum = NSUM_W'(a_data_reg[47:24]) + NSUM_W'(a_data_reg[71:48]) +
                 NSUM_W'(a_data_reg[95:72]) + NSUM_W'(a_data_reg[119:96]);
        if (!thin_reg)
        begin
            a_nsum = a_nsum + NSUM_W'(a_data_reg[143:120]) +
                     NSUM_W'(a_data_reg[167:144]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_old_reg   <= a_old;
            b_nsum_reg  <= a_nsum;
            b_r_up_reg  <= a_data_reg[191:168];
            b_k_up_reg  <= a_data_reg[215:192];
            b_r_div_reg <= SDIV_W'(r_half_reg) + SDIV_W'(a_old);
            b_k_div_reg <= SDIV_W'(k_half_reg) + SDIV_W'(a_old);
            b_perf_reg  <= a_user_reg[0];
            b_offl_reg  <= thin_reg && !a_user_reg[1];
            b_thin_reg  <= thin_reg;
        end
    end

    // Sink dividers with sideband carried alongside
    logic [SINK_W-1:0]  r_sink, k_sink;
    logic [LEVEL_W-1:0] sd_old_reg  [0:SD-1];
    logic [NSUM_W-1:0]  sd_nsum_reg [0:SD-1];
    logic               sd_perf_reg [0:SD-1];
    logic               sd_offl_reg [0:SD-1];
    logic               sd_thin_reg [0:SD-1];

    rdv_sink_div u_sink
    (
        .clk       (clk),
        .en        (en),
        .r_uptake  (b_r_up_reg),
        .r_divisor (b_r_div_reg),
        .k_uptake  (b_k_up_reg),
        .k_divisor (b_k_div_reg),
        .r_sink    (r_sink),
        .k_sink    (k_sink)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_old_reg[0]  <= b_old_reg;
            sd_nsum_reg[0] <= b_nsum_reg;
            sd_perf_reg[0] <= b_perf_reg;
            sd_offl_reg[0] <= b_offl_reg;
            sd_thin_reg[0] <= b_thin_reg;
            for (int i = 1; i < SD; i++)
            begin
                sd_old_reg[i]  <= sd_old_reg[i-1];
                sd_nsum_reg[i] <= sd_nsum_reg[i-1];
                sd_perf_reg[i] <= sd_perf_reg[i-1];
                sd_offl_reg[i] <= sd_offl_reg[i-1];
                sd_thin_reg[i] <= sd_thin_reg[i-1];
            end
        end
    end

    // Stage C: denominator and the two right-hand products
    logic [LEVEL_W-1:0] c_vx;
    logic [DEN_W-1:0]   c_diag;
    logic [DEN_W-1:0]   c_den_reg;
    logic [50:0]        c_p1_reg;
    logic [47:0]        c_p2_reg;
    logic [LEVEL_W-1:0] c_old_reg;
    logic               c_offl_reg;

    always_comb
    begin
        c_vx   = sd_perf_reg[SD-1] ? vx_rate_reg : '0;
        c_diag = {diff_rate_reg, 2'b00} + (sd_thin_reg[SD-1] ? '0 :
                 DEN_W'({diff_rate_reg, 1'b0}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_den_reg  <= c_diag + DEN_W'(decay_reg) + DEN_W'(c_vx) +
                          DEN_W'(r_sink) + DEN_W'(k_sink);
            c_p1_reg   <= 51'(diff_rate_reg) * 51'(sd_nsum_reg[SD-1]);
            c_p2_reg   <= 48'(c_vx) * 48'(vessel_reg);
            c_old_reg  <= sd_old_reg[SD-1];
            c_offl_reg <= sd_offl_reg[SD-1];
        end
    end

    // Main divider: the quotient stays below 2^24, so the top bits seed it
    logic [RHS_W-1:0] c_rhs;
    mdiv_lane_t       md_init;
    mdiv_lane_t       md_reg [0:MDIV_BITS];

    always_comb
    begin
        c_rhs            = RHS_W'(c_p1_reg) + RHS_W'(c_p2_reg);
        md_init.rem      = DEN_W'(c_rhs[RHS_W-1:CAND_W]);
        md_init.nq       = c_rhs[CAND_W-1:0];
        md_init.den      = c_den_reg;
        md_init.den_zero = (c_den_reg == '0);
        md_init.old      = c_old_reg;
        md_init.offl     = c_offl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_reg[0] <= md_init;
            for (int i = 0; i < MDIV_BITS; i++)
            begin
                md_reg[i+1] <= mdiv_step(md_reg[i]);
            end
        end
    end

    // Stage E: distance to the candidate, scaled by the weight
    mdiv_lane_t         md_last;
    logic [CAND_W-1:0]  e_cand;
    logic               e_ge;
    logic [LEVEL_W-1:0] e_diff;
    logic [40:0]        e_prod_reg;
    logic               e_ge_reg, e_offl_reg;
    logic [LEVEL_W-1:0] e_old_reg;

    always_comb
    begin
        md_last = md_reg[MDIV_BITS];
        e_cand  = md_last.den_zero ? '0 : md_last.nq;
        e_ge    = (e_cand >= md_last.old);
        e_diff  = e_ge ? (e_cand - md_last.old) : (md_last.old - e_cand);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_prod_reg <= 41'(weight_reg) * 41'(e_diff);
            e_ge_reg   <= e_ge;
            e_old_reg  <= md_last.old;
            e_offl_reg <= md_last.offl;
        end
    end

    // Stage F: step, clamp, change
    logic [24:0]        f_d;
    logic [25:0]        f_relaxed;
    logic [LEVEL_W-1:0] f_new, f_chg;
    logic [LEVEL_W-1:0] out_new_reg, out_chg_reg;

    always_comb
    begin
        f_d = e_prod_reg[40:16];
        if (e_ge_reg)
        begin
            f_relaxed = {2'b00, e_old_reg} + {1'b0, f_d};
        end
        else if (f_d >= {1'b0, e_old_reg})
        begin
            f_relaxed = '0;
        end
        else
        begin
            f_relaxed = {2'b00, e_old_reg - f_d[LEVEL_W-1:0]};
        end
        if (f_relaxed > {2'b00, vessel_reg})
        begin
            f_new = vessel_reg;
        end
        else
        begin
            f_new = f_relaxed[LEVEL_W-1:0];
        end
        f_chg = (f_new >= e_old_reg) ? (f_new - e_old_reg) : (e_old_reg - f_new);
        if (e_offl_reg)
        begin
            f_new = '0;
            f_chg = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_new_reg <= f_new;
            out_chg_reg <= f_chg;
        end
    end

    assign m_axis_tdata = {out_chg_reg, out_new_reg};

endmodule

// ----- rtl/core/rdv_checker.sv -----
// ============================================================================
// rdv_checker
// Port-level checks of the voxel relaxation core, attached by bind.
// ============================================================================
module rdv_checker
    import rdv_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [IN_USER_W-1:0]  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [LEVEL_W-1:0]    cfg_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Input side follows the output slot
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready out of step with output slot");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port refused a write");

    // An empty pipeline after reset shows no result
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result shown straight after reset");

endmodule

bind reaction_diffusion_voxel_relax_core rdv_checker u_rdv_checker (.*);

// ----- tb/rdv_relax_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdv_relax_checker
// Watches the input, output and register channels of the voxel relaxation
// core, predicts each relaxed level from the written registers and compares
// every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module rdv_relax_checker
    import rdv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LEVEL_W-1:0]    cfg_data,
    output int                    fail_count,
    output int                    pending_count
);

    // new_level sits in the low bits of the result beat
    typedef struct packed {
        logic [LEVEL_W-1:0] level_change;
        logic [LEVEL_W-1:0] new_level;
    } level_result_t;

    logic [23:0] diff_rate, decay, vx_rate, vessel, r_half, k_half;
    logic [16:0] weight;
    logic        thin;

    level_result_t expected_levels[$];

    // Michaelis-Menten sink, saturated
    function automatic logic [63:0] sink_rate(logic [63:0] uptake, logic [63:0] half,
                                              logic [63:0] old);
        logic [63:0] divisor;
        logic [63:0] q;
        divisor = half + old;
        if (divisor == 0)
            return 64'hFFFF_FFFF;
        q = (uptake << 16) / divisor;
        return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    endfunction

    function automatic level_result_t relax_voxel(logic [IN_DATA_W-1:0] d,
                                                  logic [IN_USER_W-1:0] u);
        level_result_t r;
        logic [63:0] lv[9];
        logic [63:0] old, nsum, den, rhs, cand, dlt, relaxed, vx;
        for (int i = 0; i < 9; i++)
            lv[i] = 64'(d[i*24 +: 24]);
        old = lv[0];
        if (thin && !u[1])
            return '0;
        nsum = lv[1] + lv[2] + lv[3] + lv[4];
        if (!thin)
            nsum += lv[5] + lv[6];
        vx  = u[0] ? 64'(vx_rate) : 64'd0;
        den = (thin ? 64'd4 : 64'd6) * diff_rate + decay + vx
              + sink_rate(lv[7], r_half, old) + sink_rate(lv[8], k_half, old);
        rhs = 64'(diff_rate) * nsum + vx * vessel;
        cand = (den > 0) ? rhs / den : 64'd0;
        if (cand > (64'd1 << 41))
            cand = 64'd1 << 41;
        if (cand >= old)
        begin
            dlt = (64'(weight) * (cand - old)) >> 16;
            relaxed = old + dlt;
        end
        else
        begin
            dlt = (64'(weight) * (old - cand)) >> 16;
            relaxed = (dlt >= old) ? 64'd0 : old - dlt;
        end
        if (relaxed > vessel)
            relaxed = vessel;
        r.new_level    = relaxed[23:0];
        r.level_change = (relaxed >= old) ? 24'(relaxed - old) : 24'(old - relaxed);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_count = expected_levels.size();

    always @(posedge clk or negedge rst_n)
    begin
        level_result_t got;
        level_result_t want;
        if (!rst_n)
        begin
            diff_rate = 24'd65536; decay = '0; vx_rate = 24'd65536; vessel = 24'd65536;
            weight = 17'd65536; r_half = 24'd6554; k_half = 24'd6554; thin = 1'b0;
            expected_levels.delete();
        end
        else
        begin
            // Register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DIFFUSION: diff_rate = cfg_data;
                    CFG_DECAY:     decay     = cfg_data;
                    CFG_VX_RATE:   vx_rate   = cfg_data;
                    CFG_VESSEL:    vessel    = cfg_data;
                    CFG_WEIGHT:    weight    = cfg_data[16:0];
                    CFG_R_HALF:    r_half    = cfg_data;
                    CFG_K_HALF:    k_half    = cfg_data;
                    CFG_THIN:      thin      = cfg_data[0];
                    default: ;
                endcase
            end
            // Compare result beat
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_levels.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = expected_levels.pop_front();
                    if (got.new_level !== want.new_level)
                        report_mismatch($sformatf("new_level %h, expected %h",
                                                  got.new_level, want.new_level));
                    if (got.level_change !== want.level_change)
                        report_mismatch($sformatf("level_change %h, expected %h",
                                                  got.level_change, want.level_change));
                end
            end
            // Predict input beat
            if (s_axis_tvalid && s_axis_tready)
                expected_levels = {expected_levels,
                                   relax_voxel(s_axis_tdata, s_axis_tuser)};
        end
    end

endmodule

// ----- tb/tb_reaction_diffusion_voxel_relax_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reaction_diffusion_voxel_relax_core
// Drives directed and random voxels through the relaxation core across
// several register settings, with random gaps and output stalls; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_reaction_diffusion_voxel_relax_core;
    import rdv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 63;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // old, x-, x+, y-, y+, z-, z+, r_up, k_up
    logic [IN_USER_W-1:0]  s_axis_tuser;   // perfused, on_base_layer
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // new_level, level_change
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [LEVEL_W-1:0]    cfg_data;
    int                    fail_count;
    int                    pending_count;
    int                    cycles;
    bit                    stall_enable;

    reaction_diffusion_voxel_relax_core u_top (.*);

    rdv_relax_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Short gaps mostly, an occasional long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [23:0] rand_level();
        case ($urandom_range(7))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(8));
            3, 4: return 24'($urandom_range(131072));
            default: return 24'($urandom);
        endcase
    endfunction

    // Output stalls
    initial
    begin
        m_axis_tready = 1'b0;
        cycles = 0;
        forever
        begin
            @(negedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("** reaction_diffusion_voxel_relax_core: FAILED **");
                $finish;
            end
            if (!stall_enable || $urandom_range(3) != 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(negedge clk);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_voxel(logic [IN_DATA_W-1:0] d, logic [IN_USER_W-1:0] u,
                              bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tdata  <= d;
        s_axis_tuser  <= u;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(bit gaps);
        logic [IN_DATA_W-1:0] d;
        for (int i = 0; i < 9; i++)
            d[i*24 +: 24] = rand_level();
        send_voxel(d, 2'($urandom), gaps);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic random_settings();
        write_reg(CFG_DIFFUSION, rand_level());
        write_reg(CFG_DECAY, $urandom_range(3) == 0 ? rand_level() : 24'd0);
        write_reg(CFG_VX_RATE, rand_level());
        write_reg(CFG_VESSEL, $urandom_range(3) == 0 ? 24'hFFFFFF : rand_level());
        write_reg(CFG_WEIGHT, 24'($urandom_range(131071)));
        write_reg(CFG_R_HALF, rand_level());
        write_reg(CFG_K_HALF, rand_level());
        write_reg(CFG_THIN, 24'($urandom_range(1)));
    endtask

    initial
    begin
        logic [IN_DATA_W-1:0] d;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stall_enable = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed voxels at reset settings: extremes, sink saturation
        send_voxel('0, 2'b00, 0);
        send_voxel('1, 2'b11, 0);
        send_voxel({9{24'h010000}}, 2'b01, 0);
        d = '0; d[7*24 +: 24] = 24'hFFFFFF;
        send_voxel(d, 2'b10, 0);
        d = {9{24'hFFFFFF}}; d[23:0] = 24'd0;
        send_voxel(d, 2'b00, 0);
        drain();

        // Zero denominator, zero sink divisor, wide relax weight
        write_reg(CFG_DIFFUSION, 24'd0);
        write_reg(CFG_R_HALF, 24'd0);
        write_reg(CFG_K_HALF, 24'd0);
        write_reg(CFG_WEIGHT, 24'h1FFFF);
        write_reg(CFG_VESSEL, 24'hFFFFFF);
        send_voxel('0, 2'b00, 0);
        send_voxel({24'd0, 24'd0, {7{24'hFFFFFF}}}, 2'b00, 0);
        send_voxel({{8{24'd5}}, 24'hFFFFFF}, 2'b01, 0);
        send_voxel({{8{24'd0}}, 24'h123456}, 2'b00, 0);
        drain();

        // Thin mode: off-layer voxels and ignored z neighbours
        write_reg(CFG_THIN, 24'd1);
        write_reg(CFG_DIFFUSION, 24'hFFFFFF);
        write_reg(CFG_DECAY, 24'hFFFFFF);
        write_reg(CFG_VX_RATE, 24'hFFFFFF);
        write_reg(CFG_WEIGHT, 24'd0);
        send_voxel('1, 2'b01, 0);
        send_voxel('1, 2'b10, 0);
        send_voxel({{2{24'hFFFFFF}}, {7{24'h000100}}}, 2'b11, 0);
        drain();
        write_reg(CFG_WEIGHT, 24'd65536);
        write_reg(CFG_VESSEL, 24'd0);
        send_voxel({9{24'h0F0F0F}}, 2'b11, 0);
        send_voxel({9{24'h0F0F0F}}, 2'b00, 0);
        drain();

        // Random phases under varied settings, with stalls, and with gaps in every phase but phase 3
        stall_enable = 1'b1;
        for (int ph = 0; ph < 12; ph++)
        begin
            random_settings();
            for (int n = 0; n < 135; n++)
                send_random(ph != 3);
            // Sender holds off until every result is back
            drain();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0)
            $display("** reaction_diffusion_voxel_relax_core: PASSED **");
        else
            $display("** reaction_diffusion_voxel_relax_core: FAILED **");
        $finish;
    end

endmodule
